// File: hdl/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants for the SHA-1 digest engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

  localparam int WORD_W     = 32;
  localparam int LEN_W      = 64;
  localparam int NUM_H      = 5;
  localparam int WIN_DEPTH  = 16;
  localparam int ROUNDS     = 80;
  localparam int WPOS_W     = $clog2(WIN_DEPTH);
  localparam int RC_W       = $clog2(ROUNDS);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  localparam int HCNT_W     = $clog2(NUM_H + 1);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [LEN_W-1:0]  len_t;
  // Index 0 is h0 (or working variable a)
  typedef word_t [NUM_H-1:0] hash_t;

  localparam hash_t IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                          32'hEFCDAB89, 32'h67452301};

  localparam word_t K_0 = 32'h5A827999;
  localparam word_t K_1 = 32'h6ED9EBA1;
  localparam word_t K_2 = 32'h8F1BBCDC;
  localparam word_t K_3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam word_t      PAD_WORD = {PAD_BYTE, 24'h0};

  // Bytes in one word
  localparam logic [2:0] FULL_BYTES = 3'd4;

  // Length words sit in the last two slots of the final block
  localparam logic [WPOS_W-1:0] LEN_SLOT  = WPOS_W'(WIN_DEPTH - 2);
  localparam logic [WPOS_W-1:0] LAST_SLOT = WPOS_W'(WIN_DEPTH - 1);

  // Classified word handed from the front end to the core
  typedef struct packed {
    word_t word;      // masked and padded message word
    logic  last;      // final word of the message
    logic  pad_next;  // a separate 0x80 word must follow
    len_t  bit_len;   // message length in bits, valid with last
  } msg_entry_t;

  typedef enum logic [1:0] {
    ST_FEED,
    ST_ROUND,
    ST_ADD
  } core_state_t;

  typedef enum logic [1:0] {
    PH_MSG,
    PH_PAD,
    PH_ZERO,
    PH_LENLO
  } phase_t;

endpackage

`default_nettype wire

// File: hdl/sha1_hash_engine.sv
// ----------------------------------------------------------------------------
// sha1_hash_engine
// SHA-1 digest engine with queue-style input and output channels.
// ----------------------------------------------------------------------------
// Input: msg_word carries four message bytes, first byte in bits 31:24. A
// transfer happens when push is high and full is low. last_word marks the
// final word; byte_count gives its valid leading bytes (0..4, above 4 counts
// as 4) and is ignored on other words.
// Output: while empty is low, digest_word shows the next digest word, h0
// through h4; digest_last is high on h4. A transfer happens when pop is high
// and empty is low.
// Flow: a 4-deep word queue feeds the core. Each 512-bit block passes through
// window fill, the 80 rounds on the single round unit and one chaining add;
// the core takes no new words while it runs the rounds and the add.
// Finish: after the last word the core adds padding and length words to
// finish the block (one more block when the length does not fit), then the
// digest is registered into the output buffer at the final add.
// Reset: rst clears the queue, the length count, the output buffer and loads
// the initial chaining value. If the receiver stalls, the five digest words
// wait in the output buffer; the core keeps taking input and stops only when
// it needs the buffer for the next digest.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_hash_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] msg_word,
  input  wire logic [2:0]  byte_count,
  input  wire logic        last_word,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      digest_word,
  output logic             digest_last
);
  import sha1_pkg::*;

  msg_entry_t head;
  logic       head_valid;
  logic       head_pop;
  logic       dout_free;
  logic       dout_load;
  hash_t      digest;

  sha1_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .msg_word   (msg_word),
    .byte_count (byte_count),
    .last_word  (last_word),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop)
  );

  sha1_core u_core (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .dout_free  (dout_free),
    .dout_load  (dout_load),
    .digest     (digest)
  );

  sha1_dout u_dout (
    .clk         (clk),
    .rst         (rst),
    .load        (dout_load),
    .digest      (digest),
    .free        (dout_free),
    .empty       (empty),
    .pop         (pop),
    .digest_word (digest_word),
    .digest_last (digest_last)
  );

endmodule

`default_nettype wire

// File: hdl/sha1_front.sv
// ----------------------------------------------------------------------------
// sha1_front
// Input side: masks and pads the final word, counts the message length and
// queues classified words for the core.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [31:0]         msg_word,
  input  wire logic [2:0]          byte_count,
  input  wire logic                last_word,
  output sha1_pkg::msg_entry_t     head,
  output logic                     head_valid,
  input  wire logic                head_pop
);
  import sha1_pkg::*;

  len_t                 bit_len;
  len_t                 len_sum;
  logic [2:0]           bc_sat;
  word_t                byte_mask;
  word_t                pad_bits;
  logic [5:0]           add_bits;
  msg_entry_t           entry;
  msg_entry_t           queue [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_CW-1:0]   count;
  logic                 wr_en;
  logic                 rd_en;

  // Byte count saturates at four; only honored on the last word
  assign bc_sat = (byte_count > FULL_BYTES) ? FULL_BYTES : byte_count;

  always_comb begin
    case (bc_sat)
      3'd0:    begin byte_mask = 32'h0000_0000; pad_bits = 32'h8000_0000; end
      3'd1:    begin byte_mask = 32'hFF00_0000; pad_bits = 32'h0080_0000; end
      3'd2:    begin byte_mask = 32'hFFFF_0000; pad_bits = 32'h0000_8000; end
      3'd3:    begin byte_mask = 32'hFFFF_FF00; pad_bits = 32'h0000_0080; end
      default: begin byte_mask = 32'hFFFF_FFFF; pad_bits = 32'h0000_0000; end
    endcase
  end

  // Classify the incoming word
  always_comb begin
    add_bits       = last_word ? {bc_sat, 3'b000} : 6'd32;
    len_sum        = bit_len + LEN_W'(add_bits);
    entry.word     = last_word ? ((msg_word & byte_mask) | pad_bits) : msg_word;
    entry.last     = last_word;
    entry.pad_next = last_word && (bc_sat == FULL_BYTES);
    entry.bit_len  = len_sum;
  end

  assign full       = (count == FIFO_CW'(FIFO_DEPTH));
  assign head_valid = (count != '0);
  assign head       = queue[rd_ptr];
  assign wr_en      = push && !full;
  assign rd_en      = head_pop && head_valid;

  // Length counter restarts after each message
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_len <= '0;
    end else if (wr_en) begin
      bit_len <= last_word ? '0 : len_sum;
    end
  end

  // Word queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      queue[wr_ptr] <= entry;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/sha1_core.sv
// ----------------------------------------------------------------------------
// sha1_core
// Back end: fills the 16-word window, runs one SHA-1 round per cycle and
// folds each block into the chaining value; appends padding and length.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sha1_pkg::msg_entry_t head,
  input  wire logic                head_valid,
  output logic                     head_pop,
  input  wire logic                dout_free,
  output logic                     dout_load,
  output sha1_pkg::hash_t          digest
);
  import sha1_pkg::*;

  core_state_t         state;
  core_state_t         state_next;
  phase_t              phase;
  phase_t              phase_next;
  logic [WPOS_W-1:0]   wpos;
  logic [RC_W-1:0]     rc;
  logic                final_blk;
  len_t                len_q;
  hash_t               chain;
  hash_t               work;
  hash_t               sums;
  word_t               win [WIN_DEPTH];
  word_t               push_word;
  logic                push_en;
  logic                chain_update;
  word_t               wt;
  word_t               mix;
  word_t               f;
  word_t               k;
  word_t               t;
  word_t               a, b, c, d, e;

  // Next state
  always_comb begin
    state_next = state;
    phase_next = phase;
    case (state)
      ST_FEED: begin
        if (push_en) begin
          if (wpos == LAST_SLOT) begin
            state_next = ST_ROUND;
          end
          case (phase)
            PH_MSG: begin
              if (head.last) begin
                phase_next = head.pad_next ? PH_PAD : PH_ZERO;
              end
            end
            PH_PAD:   phase_next = PH_ZERO;
            PH_ZERO: begin
              if (wpos == LEN_SLOT) begin
                phase_next = PH_LENLO;
              end
            end
            PH_LENLO: phase_next = PH_MSG;
            default:  phase_next = PH_MSG;
          endcase
        end
      end
      ST_ROUND: begin
        if (rc == RC_W'(ROUNDS - 1)) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        if (!final_blk || dout_free) begin
          state_next = ST_FEED;
        end
      end
      default: state_next = ST_FEED;
    endcase
  end

  // Control outputs
  always_comb begin
    push_en      = (state == ST_FEED) && ((phase != PH_MSG) || head_valid);
    head_pop     = (state == ST_FEED) && (phase == PH_MSG) && head_valid;
    dout_load    = (state == ST_ADD) && final_blk && dout_free;
    chain_update = (state == ST_ADD) && (!final_blk || dout_free);
    case (phase)
      PH_MSG:   push_word = head.word;
      PH_PAD:   push_word = PAD_WORD;
      PH_ZERO:  push_word = (wpos == LEN_SLOT) ? len_q[LEN_W-1:WORD_W] : '0;
      PH_LENLO: push_word = len_q[WORD_W-1:0];
      default:  push_word = '0;
    endcase
  end

  // Round function
  always_comb begin
    a   = work[0];
    b   = work[1];
    c   = work[2];
    d   = work[3];
    e   = work[4];
    mix = win[13] ^ win[8] ^ win[2] ^ win[0];
    wt  = (rc < RC_W'(WIN_DEPTH)) ? win[0] : {mix[WORD_W-2:0], mix[WORD_W-1]};
    if (rc < RC_W'(20)) begin
      f = (b & c) | (~b & d);
      k = K_0;
    end else if (rc < RC_W'(40)) begin
      f = b ^ c ^ d;
      k = K_1;
    end else if (rc < RC_W'(60)) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_2;
    end else begin
      f = b ^ c ^ d;
      k = K_3;
    end
    t = {a[WORD_W-6:0], a[WORD_W-1:WORD_W-5]} + f + e + k + wt;
  end

  // Chaining add
  always_comb begin
    for (int i = 0; i < NUM_H; i++) begin
      sums[i] = chain[i] + work[i];
    end
  end

  assign digest = sums;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FEED;
      phase     <= PH_MSG;
      wpos      <= '0;
      rc        <= '0;
      final_blk <= 1'b0;
      chain     <= IV;
    end else begin
      state <= state_next;
      phase <= phase_next;
      if (push_en) begin
        wpos <= wpos + 1'b1;
        if (phase == PH_LENLO) begin
          final_blk <= 1'b1;
        end
      end
      if (state == ST_ROUND) begin
        rc <= (rc == RC_W'(ROUNDS - 1)) ? '0 : rc + 1'b1;
      end
      if (chain_update) begin
        chain     <= final_blk ? IV : sums;
        final_blk <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (head_pop && head.last) begin
      len_q <= head.bit_len;
    end
    if (push_en) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[WIN_DEPTH-1] <= push_word;
      if (wpos == LAST_SLOT) begin
        work <= chain;
      end
    end else if (state == ST_ROUND) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[WIN_DEPTH-1] <= wt;
      work <= {d, c, {b[1:0], b[WORD_W-1:2]}, a, t};
    end
  end

endmodule

`default_nettype wire

// File: hdl/sha1_dout.sv
// ----------------------------------------------------------------------------
// sha1_dout
// Digest buffer: holds the five finished words and hands them out one per
// transfer, h0 first.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_dout (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire sha1_pkg::hash_t digest,
  output logic                 free,
  output logic                 empty,
  input  wire logic            pop,
  output logic [31:0]          digest_word,
  output logic                 digest_last
);
  import sha1_pkg::*;

  hash_t             hold;
  logic [HCNT_W-1:0] cnt;

  assign free        = (cnt == '0);
  assign empty       = (cnt == '0);
  assign digest_word = hold[0];
  assign digest_last = (cnt == HCNT_W'(1));

  // Remaining word count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= HCNT_W'(NUM_H);
    end else if (pop && !empty) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Word shifter
  always_ff @(posedge clk) begin
    if (load) begin
      hold <= digest;
    end else if (pop && !empty) begin
      hold <= {word_t'(0), hold[NUM_H-1:1]};
    end
  end

endmodule

`default_nettype wire

// File: hdl/sha1_chk.sv
// ----------------------------------------------------------------------------
// sha1_chk
// Port-level checks for the SHA-1 digest engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [31:0] digest_word,
  input wire logic        digest_last
);

  // Both queues come out of reset with nothing held
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not clear after reset");

  // A waiting digest word holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(digest_word) && $stable(digest_last)))
    else $error("digest word changed while stalled");

  // Taking h4 drains the buffer
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && digest_last) |=> empty)
    else $error("output not empty after last digest word");

  // Words before h4 are always followed by another
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !digest_last) |=> !empty)
    else $error("digest cut short");

endmodule

bind sha1_hash_engine sha1_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .digest_word (digest_word),
  .digest_last (digest_last)
);

`default_nettype wire

// File: tb/tb_sha1_hash_engine.sv
// ----------------------------------------------------------------------------
// tb_sha1_hash_engine
// Self-checking testbench for the streaming SHA-1 digest engine.
// ----------------------------------------------------------------------------
// Messages go in as word transfers and digests come out as five word
// transfers each. A directed table covers the empty message, "abc", byte
// counts from zero up to past four, masked partial words and a message that
// needs an extra padding block. Random messages of mixed length follow.
// Every digest word is checked against a table digest or an in-bench SHA-1
// model. Both sides idle at random, and the receiver holds off once for a long
// stretch so that the engine fills up and stalls its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sha1_hash_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import sha1_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int TOTAL_ITEMS    = 280;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SQUEEZE_CYCLES = 1200;
  localparam int DRAIN_CYCLES   = 250;

  localparam hash_t EMPTY_DIGEST = {32'hafd80709, 32'h95601890, 32'h3255bfef,
                                    32'h5e6b4b0d, 32'hda39a3ee};
  localparam hash_t ABC_DIGEST   = {32'h9cd0d89d, 32'h7850c26c, 32'hba3e2571,
                                    32'h4706816a, 32'ha9993e36};

  typedef struct {
    word_t      word;
    logic [2:0] count;
    logic       last;
    logic       known;   // digest column holds the expected value
    hash_t      digest;
  } stim_row_t;

  typedef struct {
    word_t word;
    logic  last;
  } digest_beat_t;

  // Directed messages
  localparam int DIR_ROWS = 20;
  stim_row_t dir_rows [DIR_ROWS] = '{
    // empty message, junk in the word is masked off
    '{32'hFFFFFFFF, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST},
    // "abc" with a junk fourth byte
    '{32'h616263A5, 3'd3, 1'b1, 1'b1, ABC_DIGEST},
    // byte count above four saturates
    '{32'h00000000, 3'd7, 1'b1, 1'b0, '0},
    '{32'hFFFFFFFF, 3'd4, 1'b1, 1'b0, '0},
    '{32'h80000001, 3'd1, 1'b1, 1'b0, '0},
    '{32'hFFFFFFFF, 3'd2, 1'b1, 1'b0, '0},
    // 13 full words then a full last word: padding spills into a second block
    '{32'h00000000, 3'd0, 1'b0, 1'b0, '0},
    '{32'hFFFFFFFF, 3'd7, 1'b0, 1'b0, '0},
    '{32'h01234567, 3'd1, 1'b0, 1'b0, '0},
    '{32'h89ABCDEF, 3'd2, 1'b0, 1'b0, '0},
    '{32'hFEDCBA98, 3'd3, 1'b0, 1'b0, '0},
    '{32'h76543210, 3'd5, 1'b0, 1'b0, '0},
    '{32'h80000000, 3'd6, 1'b0, 1'b0, '0},
    '{32'h00000001, 3'd4, 1'b0, 1'b0, '0},
    '{32'hAAAAAAAA, 3'd0, 1'b0, 1'b0, '0},
    '{32'h55555555, 3'd7, 1'b0, 1'b0, '0},
    '{32'h0F0F0F0F, 3'd2, 1'b0, 1'b0, '0},
    '{32'hF0F0F0F0, 3'd5, 1'b0, 1'b0, '0},
    '{32'h13579BDF, 3'd1, 1'b0, 1'b0, '0},
    '{32'h0F1E2D3C, 3'd4, 1'b1, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] msg_word = '0;
  logic [2:0]  byte_count = '0;
  logic        last_word = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] digest_word;
  logic        digest_last;

  // Model state
  hash_t       chain_h;
  word_t       sched [16];
  logic [63:0] msg_bits;
  logic [3:0]  slot;

  digest_beat_t digest_q [$];
  int           errors = 0;
  int           items_sent = 0;
  int           tx_idle_pct = 9;
  int           rx_idle_pct = 81;
  logic         squeeze_req = 1'b0;
  logic         squeeze_done = 1'b0;
  int           squeeze_left = 0;
  int           stall_cycles = 0;

  sha1_hash_engine uut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .msg_word    (msg_word),
    .byte_count  (byte_count),
    .last_word   (last_word),
    .empty       (empty),
    .pop         (pop),
    .digest_word (digest_word),
    .digest_last (digest_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic word_t rol(word_t v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // 80 rounds over the schedule window, then the chaining add
  function automatic void compress_block();
    word_t a, b, c, d, e, f, k, t, wt;
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        wt = sched[r];
      end else begin
        wt = rol(sched[(r - 3) & 15] ^ sched[(r - 8) & 15] ^
                 sched[(r - 14) & 15] ^ sched[r & 15], 1);
        sched[r & 15] = wt;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_2;
      end else begin
        f = b ^ c ^ d;
        k = K_3;
      end
      t = rol(a, 5) + f + e + k + wt;
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void load_word(word_t w);
    sched[slot] = w;
    slot++;
    if (slot == 0) compress_block();
  endfunction

  // Absorb one message word; returns 1 with the digest when the message ends
  function automatic bit absorb_word(word_t w, logic [2:0] bc, logic lw,
                                     output hash_t digest);
    int unsigned n;
    digest = '0;
    if (!lw) begin
      msg_bits += 64'd32;
      load_word(w);
      return 1'b0;
    end
    n = (bc > FULL_BYTES) ? 4 : bc;
    msg_bits += 64'(8 * n);
    if (n == 4) begin
      load_word(w);
      load_word(PAD_WORD);
    end else begin
      load_word((n == 0 ? '0 : (w & ~(32'hFFFFFFFF >> (8 * n)))) | (PAD_WORD >> (8 * n)));
    end
    while (slot != LEN_SLOT) load_word('0);
    load_word(msg_bits[63:32]);
    load_word(msg_bits[31:0]);
    digest   = chain_h;
    chain_h  = IV;
    msg_bits = '0;
    slot     = '0;
    return 1'b1;
  endfunction

  // One input transfer, with random idle cycles ahead of it
  task automatic send_word(word_t w, logic [2:0] bc, logic lw, logic known,
                           hash_t table_digest);
    hash_t d;
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    msg_word   <= w;
    byte_count <= bc;
    last_word  <= lw;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
    if (absorb_word(w, bc, lw, d)) begin
      if (known) d = table_digest;
      for (int i = 0; i < 5; i++) digest_q.push_back('{word: d[i], last: (i == 4)});
    end
  endtask

  // Receiver: random pop, plus one long hold-off once squeeze is requested
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (squeeze_req && !squeeze_done) begin
        squeeze_left = SQUEEZE_CYCLES;
        squeeze_done <= 1'b1;
      end
      if (squeeze_left > 0) begin
        squeeze_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Digest checker and watchdog
  always @(posedge clk) begin
    digest_beat_t want;
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if ((push && !full) || (pop && !empty)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no transfer for %0d cycles", $time, stall_cycles);
        $display("TB_ERROR");
        $finish;
      end else if (pop && !empty) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word %h last %b", $time, digest_word,
                   digest_last);
          errors++;
        end else begin
          want = digest_q.pop_front();
          if (digest_word !== want.word) begin
            $display("%0t: digest_word expected %h actual %h", $time, want.word,
                     digest_word);
            errors++;
          end
          if (digest_last !== want.last) begin
            $display("%0t: digest_last expected %b actual %b", $time, want.last,
                     digest_last);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int         n_words;
    word_t      w;
    logic [2:0] bc;

    chain_h  = IV;
    msg_bits = '0;
    slot     = '0;
    foreach (sched[i]) sched[i] = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (int i = 0; i < DIR_ROWS; i++)
      send_word(dir_rows[i].word, dir_rows[i].count, dir_rows[i].last,
                dir_rows[i].known, dir_rows[i].digest);

    // Random messages; idling pattern changes at message boundaries
    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent < 110) begin
        tx_idle_pct = 9;
        rx_idle_pct <= 81;
      end else if (items_sent < 200) begin
        tx_idle_pct = 81;
        rx_idle_pct <= 9;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        squeeze_req <= 1'b1;
      end
      case ($urandom_range(0, 7))
        0, 1:    n_words = $urandom_range(12, 17);
        2:       n_words = $urandom_range(30, 47);
        default: n_words = $urandom_range(0, 11);
      endcase
      for (int i = 0; i <= n_words; i++) begin
        case ($urandom_range(0, 7))
          0:       w = '0;
          1:       w = '1;
          default: w = $urandom;
        endcase
        bc = $urandom_range(0, 7);
        send_word(w, bc, (i == n_words), 1'b0, '0);
      end
    end

    // Drain
    push <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
